/* src/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and codes for the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int SZ_W    = 4;
    localparam int POS_W   = 3;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 35;

    // input item kinds
    localparam logic [1:0] KIND_WRITE_A = 2'd0;
    localparam logic [1:0] KIND_WRITE_B = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE_A,
        OP_WRITE_B,
        OP_COMPUTE
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [SZ_W-1:0] rows_a;
        logic [SZ_W-1:0] inner_dim;
        logic [SZ_W-1:0] cols_b;
    } size_cfg_t;

endpackage

/* src/mm_front.sv */
// ----------------------------------------------------------------------------
// mm_front
// Accepts input items, drops items with no effect, queues the rest.
// ----------------------------------------------------------------------------
module mm_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        kind,
    input  logic [mm_pkg::POS_W-1:0]          row_index,
    input  logic [mm_pkg::POS_W-1:0]          col_index,
    input  logic signed [mm_pkg::ELEM_W-1:0]  element_value,
    output logic                              q_valid,
    input  logic                              q_ready,
    output mm_pkg::cmd_t                      q_cmd
);
    import mm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       keep;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.row   = row_index;
        cmd_in.col   = col_index;
        cmd_in.value = element_value;
        cmd_in.op    = OP_COMPUTE;
        keep         = 1'b0;
        unique case (kind)
            KIND_WRITE_A:
            begin
                cmd_in.op = OP_WRITE_A;
                keep = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
            end
            KIND_WRITE_B:
            begin
                cmd_in.op = OP_WRITE_B;
                keep = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
            end
            KIND_COMPUTE:
            begin
                cmd_in.op = OP_COMPUTE;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready && keep;
    assign q_valid    = (count_reg != 2'd0);
    assign pop        = q_valid && q_ready;
    assign q_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* src/mm_back.sv */
// ----------------------------------------------------------------------------
// mm_back
// Element stores, product sequencer, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module mm_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  mm_pkg::cmd_t                      q_cmd,
    input  mm_pkg::size_cfg_t                 sizes,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [mm_pkg::POS_W-1:0]          out_row,
    output logic [mm_pkg::POS_W-1:0]          out_col,
    output logic signed [mm_pkg::ACC_W-1:0]   product_value,
    output logic                              last
);
    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [IDX_W-1:0]          i_reg;
    logic [IDX_W-1:0]          i_next;
    logic [IDX_W-1:0]          j_reg;
    logic [IDX_W-1:0]          j_next;
    logic [IDX_W-1:0]          t_reg;
    logic [IDX_W-1:0]          t_next;

    logic signed [ELEM_W-1:0]  mem_a [DEPTH];
    logic signed [ELEM_W-1:0]  mem_b [DEPTH];
    logic signed [ELEM_W-1:0]  rd_a_reg;
    logic signed [ELEM_W-1:0]  rd_b_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      first1_reg;
    logic                      first2_reg;

    logic                      out_valid_reg;
    logic [POS_W-1:0]          out_row_reg;
    logic [POS_W-1:0]          out_col_reg;
    logic signed [ACC_W-1:0]   out_value_reg;
    logic                      out_last_reg;

    logic [SZ_W-1:0]           m_last;
    logic [SZ_W-1:0]           k_last;
    logic [SZ_W-1:0]           n_last;
    logic                      issue;
    logic                      we_a;
    logic                      we_b;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr_a;
    logic [ADDR_W-1:0]         rd_addr_b;
    logic                      out_free;
    logic                      emit;
    logic                      is_last;

    function automatic logic [SZ_W-1:0] eff_last(input logic [SZ_W-1:0] v);
        logic [SZ_W-1:0] s;
        begin
            if (v == '0)
            begin
                s = SZ_W'(1);
            end
            else if (32'(v) > MAX_DIM)
            begin
                s = SZ_W'(MAX_DIM);
            end
            else
            begin
                s = v;
            end
            return s - SZ_W'(1);
        end
    endfunction

    assign m_last = eff_last(sizes.rows_a);
    assign k_last = eff_last(sizes.inner_dim);
    assign n_last = eff_last(sizes.cols_b);

    assign q_ready   = (state_reg == S_IDLE);
    assign we_a      = q_valid && q_ready && (q_cmd.op == OP_WRITE_A);
    assign we_b      = q_valid && q_ready && (q_cmd.op == OP_WRITE_B);
    assign wr_addr   = ADDR_W'(32'(q_cmd.row) * MAX_DIM + 32'(q_cmd.col));
    assign rd_addr_a = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(t_reg));
    assign rd_addr_b = ADDR_W'(32'(t_reg) * MAX_DIM + 32'(j_reg));
    assign issue     = (state_reg == S_ISSUE);
    assign out_free  = !out_valid_reg || result_ready;
    assign is_last   = (SZ_W'(i_reg) == m_last) && (SZ_W'(j_reg) == n_last);
    assign emit      = (state_reg == S_DRAIN) && !v1_reg && !v2_reg && out_free;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_COMPUTE)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (SZ_W'(t_reg) == k_last)
                begin
                    t_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (emit)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        if (SZ_W'(j_reg) == n_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= q_cmd.value;
        end
        if (we_b)
        begin
            mem_b[wr_addr] <= q_cmd.value;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= (t_reg == '0);
        first2_reg <= first1_reg;
        prod_reg   <= rd_a_reg * rd_b_reg;
        if (v2_reg)
        begin
            acc_reg <= first2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (emit)
        begin
            out_row_reg   <= POS_W'(i_reg);
            out_col_reg   <= POS_W'(j_reg);
            out_value_reg <= acc_reg;
            out_last_reg  <= is_last;
        end
    end

    assign result_valid  = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_value_reg;
    assign last          = out_last_reg;

endmodule

/* src/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense product C = A x B of signed Q8.8 matrices up to MAX_DIM square.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready): kind 0 writes A[row][col], kind 1
//   writes B[row][col], kind 2 emits all of C in row-major order; kind 3 and
//   writes outside MAX_DIM are dropped. Items pass through a two-entry queue.
//   Result channel (result_valid/result_ready): out_row, out_col,
//   product_value (16 fractional bits) and last on the final element.
//   Sizes rows_a, inner_dim, cols_b sit at APB addresses 0x0, 0x4, 0x8; 0
//   acts as 1, values above MAX_DIM saturate. Write sizes only when idle.
//   The back end takes writes only while idle. A product element issues one
//   store read per cycle through the read, multiply and accumulate stages;
//   a compute holds the queue until the last element of C is emitted.
//   Reset clears the sizes to 8 and empties queue and pipeline; store contents
//   are undefined until written. A stalled result holds the sequencer while
//   the input queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        kind,
    input  logic [mm_pkg::POS_W-1:0]          row_index,
    input  logic [mm_pkg::POS_W-1:0]          col_index,
    input  logic signed [mm_pkg::ELEM_W-1:0]  element_value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [mm_pkg::POS_W-1:0]          out_row,
    output logic [mm_pkg::POS_W-1:0]          out_col,
    output logic signed [mm_pkg::ACC_W-1:0]   product_value,
    output logic                              last
);
    import mm_pkg::*;

    size_cfg_t sizes_reg;
    logic      q_valid;
    logic      q_ready;
    cmd_t      q_cmd;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg.rows_a    <= SZ_W'(8);
            sizes_reg.inner_dim <= SZ_W'(8);
            sizes_reg.cols_b    <= SZ_W'(8);
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ROWS_A:    sizes_reg.rows_a    <= pwdata[SZ_W-1:0];
                REG_INNER_DIM: sizes_reg.inner_dim <= pwdata[SZ_W-1:0];
                REG_COLS_B:    sizes_reg.cols_b    <= pwdata[SZ_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS_A:    prdata = 32'(sizes_reg.rows_a);
            REG_INNER_DIM: prdata = 32'(sizes_reg.inner_dim);
            REG_COLS_B:    prdata = 32'(sizes_reg.cols_b);
            default:       prdata = '0;
        endcase
    end

    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd)
    );

    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .sizes         (sizes_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

endmodule
